// ----- rtl/sm4_block_encrypt_assert.svh -----
// Assertion macros used by the SM4 block encrypt RTL.
`ifndef SM4_BLOCK_ENCRYPT_ASSERT_SVH
`define SM4_BLOCK_ENCRYPT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SM4_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SM4_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sm4_pkg.sv -----
package sm4_pkg;

   localparam int ROUND_COUNT = 32;
   localparam int RK_AW       = $clog2(ROUND_COUNT);

   typedef logic [31:0]      word_type;
   typedef logic [RK_AW-1:0] rk_addr_type;

   localparam rk_addr_type ROUND_LAST = rk_addr_type'(ROUND_COUNT - 1);

   // Item kinds carried on tuser
   localparam logic KIND_KEY     = 1'b0;
   localparam logic KIND_ENCRYPT = 1'b1;

   // Write side of the round key store
   typedef struct packed {
      logic        en;
      rk_addr_type addr;
      word_type    data;
   } rk_write_type;

   // Standard SM4 S-box
   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

endpackage

// ----- rtl/sm4_block_encrypt.sv -----
// Key write: accepted with no response; key writes stream one per cycle while idle.
// Encrypt: one round per cycle through a single shared round unit fed by the round
// key memory; the final round waits until the response register is free.
// Requests are taken only in idle; a waiting response does not block the next.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_tvalid;
// round keys are not cleared and must all be written before the first block.
`include "sm4_block_encrypt_assert.svh"

module sm4_block_encrypt
   import sm4_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // [4:0] key_index, [36:5] round_key, [100:37] block_hi, [164:101] block_lo,
   // [167:165] zero
   input  logic [167:0] req_tdata,
   input  logic         req_tuser,   // [0] kind
   input  logic         req_tlast,   // last_block

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [63:0] cipher_hi, [127:64] cipher_lo
   output logic [127:0] rsp_tdata,
   output logic         rsp_tlast    // last_out
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_ROUND = 2'b10
   } state_type;

   state_type    state_ff, state_in;
   rk_addr_type  cnt_ff, cnt_in;
   word_type     x_ff [4];
   word_type     x_in [4];
   logic         last_ff, last_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_data_ff, rsp_data_in;
   logic         rsp_last_ff, rsp_last_in;

   logic         req_accept;
   logic         key_accept;
   logic         enc_accept;
   logic         last_round;
   logic         out_free;
   logic         advance;
   rk_write_type rk_wr;
   rk_addr_type  rk_rd_addr;
   word_type     rk;
   word_type     x_new;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign key_accept = req_accept && (req_tuser == KIND_KEY);
   assign enc_accept = req_accept && (req_tuser == KIND_ENCRYPT);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_round = (state_ff == ST_ROUND) && (cnt_ff == ROUND_LAST);
   // final round waits until the response register is free
   assign advance    = (state_ff == ST_ROUND) && (!last_round || out_free);

   // Round key store
   always_comb begin
      rk_wr.en   = key_accept;
      rk_wr.addr = req_tdata[4:0];
      rk_wr.data = req_tdata[36:5];
   end

   // Prefetch key of the next round; hold the address while stalled
   always_comb begin
      if (state_ff == ST_ROUND) begin
         rk_rd_addr = advance ? rk_addr_type'(cnt_ff + 1'b1) : cnt_ff;
      end else begin
         rk_rd_addr = '0;
      end
   end

   sm4_key_ram u_key_ram (
      .clock   (clock),
      .wr      (rk_wr),
      .rd_addr (rk_rd_addr),
      .rd_data (rk)
   );

   sm4_round_unit u_round (
      .x0 (x_ff[0]),
      .x1 (x_ff[1]),
      .x2 (x_ff[2]),
      .x3 (x_ff[3]),
      .rk (rk),
      .x4 (x_new)
   );

   // Sequencer and data path
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (enc_accept) begin
               state_in = ST_ROUND;
               cnt_in   = '0;
               x_in[0]  = req_tdata[100:69];
               x_in[1]  = req_tdata[68:37];
               x_in[2]  = req_tdata[164:133];
               x_in[3]  = req_tdata[132:101];
               last_in  = req_tlast;
            end
         end
         ST_ROUND: begin
            if (advance) begin
               x_in[0] = x_ff[1];
               x_in[1] = x_ff[2];
               x_in[2] = x_ff[3];
               x_in[3] = x_new;
               cnt_in  = rk_addr_type'(cnt_ff + 1'b1);
               if (last_round) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {x_ff[2], x_ff[1], x_new, x_ff[3]};
                  rsp_last_in  = last_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   `SM4_ASSERT_NEXT(a_enc_starts_round0, clock, reset, enc_accept,
      (state_ff == ST_ROUND) && (cnt_ff == '0), "encrypt did not start at round 0")
   `SM4_ASSERT_NEXT(a_key_write_stays_idle, clock, reset, key_accept,
      (state_ff == ST_IDLE) && !$rose(rsp_valid_ff), "key write disturbed sequencer")
   `SM4_ASSERT_NEXT(a_round_counts_up, clock, reset,
      advance && !last_round, cnt_ff == rk_addr_type'($past(cnt_ff) + 1'b1),
      "round counter skipped")
   `SM4_ASSERT_NEXT(a_stall_holds_round, clock, reset,
      (state_ff == ST_ROUND) && !advance,
      (state_ff == ST_ROUND) && (cnt_ff == ROUND_LAST), "stalled round lost")
   `SM4_ASSERT_NOW(a_rsp_after_last_round, clock, reset, $rose(rsp_valid_ff),
      $past(last_round), "response without final round")

endmodule

// ----- rtl/sm4_key_ram.sv -----
module sm4_key_ram
   import sm4_pkg::*;
(
   input  logic         clock,
   input  rk_write_type wr,
   input  rk_addr_type  rd_addr,
   output word_type     rd_data
);

   word_type key_mem [ROUND_COUNT];
   word_type rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= key_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sm4_round_unit.sv -----
module sm4_round_unit
   import sm4_pkg::*;
(
   input  word_type x0,
   input  word_type x1,
   input  word_type x2,
   input  word_type x3,
   input  word_type rk,
   output word_type x4
);

   word_type a;
   word_type b;
   word_type l_out;

   // Nonlinear layer: four S-box lookups
   always_comb begin
      a = x1 ^ x2 ^ x3 ^ rk;
      b = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
   end

   // Linear layer L(B) = B ^ rotl2 ^ rotl10 ^ rotl18 ^ rotl24
   assign l_out = b
                ^ {b[29:0], b[31:30]}
                ^ {b[21:0], b[31:22]}
                ^ {b[13:0], b[31:14]}
                ^ {b[7:0],  b[31:8]};

   assign x4 = x0 ^ l_out;

endmodule

// ----- verif/sm4_block_encrypt_tb.sv -----
module sm4_block_encrypt_tb;
   import sm4_pkg::*;

   localparam int RANDOM_ITEMS   = 1300;
   localparam int PHASE_ITEMS    = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int PRINT_LIMIT    = 40;

   // Stall pattern, rotated every PHASE_ITEMS accepted requests
   typedef enum int {
      STREAM_FREE,
      SENDER_GAPS,
      RECEIVER_STALLS,
      BOTH_IDLE
   } idle_mode_type;

   typedef struct {
      logic        kind;
      rk_addr_type key_index;
      word_type    round_key;
      logic [63:0] block_hi;
      logic [63:0] block_lo;
      logic        last_block;
   } sm4_req_type;

   typedef struct {
      logic [63:0] cipher_hi;
      logic [63:0] cipher_lo;
      logic        last_out;
   } cipher_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] req_tdata  = '0;
   logic         req_tuser  = KIND_KEY;
   logic         req_tlast  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         rsp_tlast;

   sm4_req_type pending_req [$];
   cipher_type  cipher_expect [$];
   word_type    key_sched [ROUND_COUNT];
   int          items_accepted = 0;
   int          idle_cycles    = 0;
   int          error_count    = 0;
   bit          req_taken      = 1'b0;

   // SM4 S-box, kept apart from the package copy
   localparam logic [7:0] SBOX_LUT [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   sm4_block_encrypt dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic word_type rotl(word_type v, int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // Byte substitution followed by the linear diffusion map
   function automatic word_type round_mix(word_type a);
      word_type b;
      b = {SBOX_LUT[a[31:24]], SBOX_LUT[a[23:16]], SBOX_LUT[a[15:8]], SBOX_LUT[a[7:0]]};
      return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
   endfunction

   // 32 rounds over the current key schedule; output words reversed
   function automatic cipher_type encrypt_block(logic [63:0] hi, logic [63:0] lo, logic last);
      word_type   w [4];
      word_type   nx;
      cipher_type res;
      w[0] = hi[63:32];
      w[1] = hi[31:0];
      w[2] = lo[63:32];
      w[3] = lo[31:0];
      for (int r = 0; r < ROUND_COUNT; r++) begin
         nx   = w[0] ^ round_mix(w[1] ^ w[2] ^ w[3] ^ key_sched[r]);
         w[0] = w[1];
         w[1] = w[2];
         w[2] = w[3];
         w[3] = nx;
      end
      res.cipher_hi = {w[3], w[2]};
      res.cipher_lo = {w[1], w[0]};
      res.last_out  = last;
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch on %s: expected %h, got %h", field, want, got);
   endtask

   // Key write; block fields carry junk the block must ignore
   task automatic push_key(rk_addr_type idx, word_type rk);
      sm4_req_type item;
      item.kind       = KIND_KEY;
      item.key_index  = idx;
      item.round_key  = rk;
      item.block_hi   = {$urandom, $urandom};
      item.block_lo   = {$urandom, $urandom};
      item.last_block = 1'($urandom_range(1));
      pending_req.push_back(item);
   endtask

   // Encrypt request; key fields carry junk that must not reach the store
   task automatic push_block(logic [63:0] hi, logic [63:0] lo, logic last);
      sm4_req_type item;
      item.kind       = KIND_ENCRYPT;
      item.key_index  = rk_addr_type'($urandom_range(ROUND_COUNT - 1));
      item.round_key  = $urandom;
      item.block_hi   = hi;
      item.block_lo   = lo;
      item.last_block = last;
      pending_req.push_back(item);
   endtask

   // Driver: presents queued transactions at the falling edge
   always @(negedge clock) begin
      sm4_req_type   item;
      idle_mode_type mode;
      bit            gap;
      bit            stall;
      mode = idle_mode_type'((items_accepted / PHASE_ITEMS) % 4);
      case (mode)
         SENDER_GAPS: begin
            gap   = $urandom_range(99) < 79;
            stall = 1'b0;
         end
         RECEIVER_STALLS: begin
            gap   = 1'b0;
            stall = $urandom_range(99) < 79;
         end
         BOTH_IDLE: begin
            gap   = $urandom_range(99) < 20;
            stall = $urandom_range(99) < 20;
         end
         default: begin
            gap   = 1'b0;
            stall = 1'b0;
         end
      endcase
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (pending_req.size() != 0 && !gap) begin
               item = pending_req.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {3'b000, item.block_lo, item.block_hi, item.round_key,
                              item.key_index};
               req_tuser  <= item.kind;
               req_tlast  <= item.last_block;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= !stall;
      end
   end

   // Monitor: predicts on request transactions, checks response transactions
   always @(posedge clock) begin
      cipher_type want;
      bit         req_fire;
      bit         rsp_fire;
      req_fire  = !reset && req_tvalid && req_tready;
      rsp_fire  = !reset && rsp_tvalid && rsp_tready;
      req_taken = req_fire;

      if (rsp_fire) begin
         if (cipher_expect.size() == 0) begin
            report_mismatch("unexpected response", '0, rsp_tdata[63:0]);
         end else begin
            want = cipher_expect.pop_front();
            if (rsp_tdata[63:0] !== want.cipher_hi)
               report_mismatch("cipher_hi", want.cipher_hi, rsp_tdata[63:0]);
            if (rsp_tdata[127:64] !== want.cipher_lo)
               report_mismatch("cipher_lo", want.cipher_lo, rsp_tdata[127:64]);
            if (rsp_tlast !== want.last_out)
               report_mismatch("last_out", 64'(want.last_out), 64'(rsp_tlast));
         end
      end

      if (req_fire) begin
         items_accepted++;
         if (req_tuser == KIND_KEY)
            key_sched[req_tdata[4:0]] = req_tdata[36:5];
         else
            cipher_expect.push_back(encrypt_block(req_tdata[100:37], req_tdata[164:101],
                                                  req_tlast));
      end

      // Watchdog on cycles with no transaction on either side
      if (!reset) begin
         if (req_fire || rsp_fire)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Stimulus and end of test
   initial begin
      // Full key schedule first, with both extremes of the key value
      for (int i = 0; i < ROUND_COUNT; i++) begin
         if (i == 0)
            push_key(rk_addr_type'(i), 32'h0000_0000);
         else if (i == ROUND_COUNT - 1)
            push_key(rk_addr_type'(i), 32'hffff_ffff);
         else
            push_key(rk_addr_type'(i), $urandom);
      end

      // Directed blocks: extremes, known pattern, last flag both ways
      push_block(64'h0, 64'h0, 1'b0);
      push_block('1, '1, 1'b1);
      push_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
      push_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b1);
      // rewrite the end keys with swapped extremes, then reuse the block
      push_key(ROUND_LAST, 32'h0000_0000);
      push_key('0, 32'hffff_ffff);
      push_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
      // key write straight into an encrypt, then back-to-back encrypts
      push_key(rk_addr_type'(7), $urandom);
      push_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
      push_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      push_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);

      // Random mix, mostly encrypts with key updates sprinkled in
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(99) < 20)
            push_key(rk_addr_type'($urandom_range(ROUND_COUNT - 1)), $urandom);
         else
            push_block({$urandom, $urandom}, {$urandom, $urandom},
                       1'($urandom_range(1)));
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_req.size() != 0 || req_tvalid)
         @(posedge clock);
      while (cipher_expect.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
